// ===== hdl/ipv6p_pkg.sv =====
// Shared types and constants for the IPv6 text address parser.
package ipv6p_pkg;

    localparam int unsigned NUM_GROUPS  = 8;
    localparam int unsigned GROUP_W     = 16;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned HALF_W      = 64;
    localparam logic [7:0]  CHAR_COLON  = 8'h3A;
    localparam logic [3:0]  GROUP_FULL  = 4'd8;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_REPEAT_DC  = 3'd1,
        ST_GROUP_WIDE = 3'd2,
        ST_BAD_CHAR   = 3'd3,
        ST_TOO_MANY   = 3'd4,
        ST_SHORT      = 3'd5,
        ST_OVERFLOW   = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0] character;
        logic       is_end;
    } t_in;

    typedef struct packed {
        t_status             status;
        logic [HALF_W-1:0]   addr_high;
        logic [HALF_W-1:0]   addr_low;
    } t_out;

    typedef logic [NUM_GROUPS-1:0][GROUP_W-1:0] t_groups;

    typedef struct packed {
        t_groups             head;
        t_groups             tail;
        logic [COUNT_W-1:0]  head_count;
        logic [COUNT_W-1:0]  tail_count;
        logic [GROUP_W-1:0]  group_value;
        logic                in_group;
        logic                past_double;
        logic                last_was_colon;
        logic                double_seen;
        logic                double_repeated;
        t_status             first_error;
    } t_state;

endpackage

// ===== hdl/ipv6p_step.sv =====
// Per-character next-state logic: group close, digit shift-in, colon tracking.
module ipv6p_step (
    input  ipv6p_pkg::t_state i_st,
    input  ipv6p_pkg::t_in    i_item,
    output ipv6p_pkg::t_state o_closed,
    output ipv6p_pkg::t_state o_next
);

    // {valid, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    logic [4:0] hex;
    logic       is_colon;
    logic       is_hex;
    logic       close_en;

    assign hex      = hex_decode(i_item.character);
    assign is_colon = (i_item.character == ipv6p_pkg::CHAR_COLON);
    assign is_hex   = hex[4];
    assign close_en = i_item.is_end || !is_hex;

    // group close happens before anything else the character does
    always_comb begin
        o_closed = i_st;
        if (close_en && i_st.in_group) begin
            if (i_st.first_error == ipv6p_pkg::ST_OK) begin
                if (i_st.past_double) begin
                    if (i_st.tail_count >= ipv6p_pkg::GROUP_FULL) begin
                        o_closed.first_error = ipv6p_pkg::ST_TOO_MANY;
                    end else begin
                        o_closed.tail[i_st.tail_count[2:0]] = i_st.group_value;
                        o_closed.tail_count = i_st.tail_count + 4'd1;
                    end
                end else begin
                    if (i_st.head_count >= ipv6p_pkg::GROUP_FULL) begin
                        o_closed.first_error = ipv6p_pkg::ST_TOO_MANY;
                    end else begin
                        o_closed.head[i_st.head_count[2:0]] = i_st.group_value;
                        o_closed.head_count = i_st.head_count + 4'd1;
                    end
                end
            end
            o_closed.in_group    = 1'b0;
            o_closed.group_value = '0;
        end
    end

    always_comb begin
        o_next = i_st;
        if (i_item.is_end) begin
            o_next = '0;
        end else if (is_colon) begin
            o_next = o_closed;
            if (i_st.last_was_colon) begin
                if (i_st.double_seen) begin
                    o_next.double_repeated = 1'b1;
                end
                o_next.double_seen = 1'b1;
                o_next.past_double = 1'b1;
            end
            o_next.last_was_colon = 1'b1;
        end else if (is_hex) begin
            if (i_st.first_error == ipv6p_pkg::ST_OK) begin
                // a fifth significant digit would overflow the group
                if (i_st.group_value[15:12] != 4'd0) begin
                    o_next.first_error = ipv6p_pkg::ST_GROUP_WIDE;
                end else begin
                    o_next.group_value = {i_st.group_value[11:0], hex[3:0]};
                    o_next.in_group    = 1'b1;
                end
            end
            o_next.last_was_colon = 1'b0;
        end else begin
            o_next = o_closed;
            if (o_closed.first_error == ipv6p_pkg::ST_OK) begin
                o_next.first_error = ipv6p_pkg::ST_BAD_CHAR;
            end
            o_next.last_was_colon = 1'b0;
        end
    end

endmodule

// ===== hdl/ipv6p_finish.sv =====
// End-of-text logic: final status and placement of head/tail groups.
module ipv6p_finish (
    input  ipv6p_pkg::t_state i_closed,
    output ipv6p_pkg::t_out   o_result
);

    ipv6p_pkg::t_status status;
    ipv6p_pkg::t_groups g;
    logic [4:0]         head_plus_tail;

    assign head_plus_tail = {1'b0, i_closed.head_count} + {1'b0, i_closed.tail_count};

    always_comb begin
        priority if (i_closed.double_repeated) begin
            status = ipv6p_pkg::ST_REPEAT_DC;
        end else if (i_closed.first_error != ipv6p_pkg::ST_OK) begin
            status = i_closed.first_error;
        end else if (!i_closed.double_seen && i_closed.head_count != ipv6p_pkg::GROUP_FULL) begin
            status = ipv6p_pkg::ST_SHORT;
        end else if (i_closed.double_seen && head_plus_tail > 5'd8) begin
            status = ipv6p_pkg::ST_OVERFLOW;
        end else begin
            status = ipv6p_pkg::ST_OK;
        end
    end

    // head fills from the left, tail is right-aligned, zeros in between
    always_comb begin
        logic [4:0] pos;
        for (int i = 0; i < ipv6p_pkg::NUM_GROUPS; i++) begin
            pos  = 5'(i) + {1'b0, i_closed.tail_count};
            g[i] = '0;
            if (4'(i) < i_closed.head_count) begin
                g[i] = i_closed.head[i];
            end else if (pos >= 5'd8) begin
                g[i] = i_closed.tail[pos[2:0]];
            end
        end
    end

    always_comb begin
        o_result.status    = status;
        o_result.addr_high = '0;
        o_result.addr_low  = '0;
        if (status == ipv6p_pkg::ST_OK) begin
            o_result.addr_high = {g[0], g[1], g[2], g[3]};
            o_result.addr_low  = {g[4], g[5], g[6], g[7]};
        end
    end

endmodule

// ===== hdl/ipv6_text_address_parser_top.sv =====
// IPv6 text address parser: input register, parse state, result register.
// Takes one text byte per cycle, closed by an end item; the end item's result
// (status and 128-bit address) is loaded into the result register as the end
// item is processed from the input register, and the parser is immediately
// ready for the next address. Throughput is one item per clock, set by the
// combinational state update between the input register and the parse state;
// an end item waits in the input register only while the result register is
// full and the output side stalls.
module ipv6_text_address_parser_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ipv6p_pkg::t_in    i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ipv6p_pkg::t_out   o_out_data
);

    logic              r_in_valid;
    logic              n_in_valid;
    ipv6p_pkg::t_in    r_in;
    ipv6p_pkg::t_state r_st;
    ipv6p_pkg::t_state n_st;
    ipv6p_pkg::t_state closed_st;
    logic              r_out_valid;
    logic              n_out_valid;
    ipv6p_pkg::t_out   r_out;
    ipv6p_pkg::t_out   result;

    logic in_fire;
    logic out_free;
    logic proc_fire;
    logic end_fire;

    ipv6p_step u_step (
        .i_st     (r_st),
        .i_item   (r_in),
        .o_closed (closed_st),
        .o_next   (n_st)
    );

    ipv6p_finish u_finish (
        .i_closed (closed_st),
        .o_result (result)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    // only an end item needs room in the result register
    assign proc_fire  = r_in_valid && (!r_in.is_end || out_free);
    assign end_fire   = proc_fire && r_in.is_end;
    assign o_in_stall = r_in_valid && !proc_fire;
    assign in_fire    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_fire) begin
            n_in_valid = 1'b1;
        end else if (proc_fire) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (end_fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (proc_fire) begin
                r_st <= n_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in_data;
        end
        if (end_fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_result_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(end_fire))
        else $error("result appeared without an end item");

    a_error_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ipv6p_pkg::ST_OK)
            |-> (r_out.addr_high == '0 && r_out.addr_low == '0))
        else $error("nonzero address with error status");

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        end_fire |=> (r_st == '0))
        else $error("parse state not cleared after end item");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.head_count <= ipv6p_pkg::GROUP_FULL)
            && (r_st.tail_count <= ipv6p_pkg::GROUP_FULL))
        else $error("group count beyond eight");

endmodule
